// ----- rtl/core/load_settle_detector_core_defines.svh -----
// Assertion macros for the load settle detector checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef LOAD_SETTLE_DETECTOR_CORE_DEFINES_SVH
`define LOAD_SETTLE_DETECTOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("load settle detector: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("load settle detector: next-cycle check failed");

`endif

// ----- rtl/core/lsd_pkg.sv -----
// Shared types and constants of the load settle detector.
// No dependencies; lsd_if, the core and the checker import it.
`timescale 1ns / 1ps

package lsd_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 8;
  localparam int THR_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRACTION    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_WEIGHT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_THRESHOLD = CFG_IDX_W'(3);

  // Register values after reset.
  localparam logic                       DIRECTION_RST = 1'b0;
  localparam logic [FRAC_W-1:0]          FRACTION_RST  = FRAC_W'(192);
  localparam logic signed [SAMPLE_W-1:0] REFERENCE_RST = '0;
  localparam logic [THR_W-1:0]           THRESHOLD_RST = THR_W'(1024);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_GATE,
    ST_ACCUM,
    ST_SQUARE,
    ST_DIVIDE,
    ST_FIX,
    ST_CORRECT,
    ST_FINISH
  } lsd_state_t;

endpackage

// ----- rtl/core/lsd_if.sv -----
// Channel interfaces of the load settle detector: sample input, result output
// and configuration write. Depends on lsd_pkg.
`timescale 1ns / 1ps

interface lsd_in_if import lsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lsd_out_if import lsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       in_window;
  logic                       settled;
  logic signed [SAMPLE_W-1:0] window_mean;

  modport source (output valid, output in_window, output settled, output window_mean,
                  input ready);
  modport sink   (input valid, input in_window, input settled, input window_mean,
                  output ready);
endinterface

interface lsd_cfg_if import lsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/lsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/core/lsd_mul.sv -----
// Shared unsigned multiplier of the load settle detector, one register stage.
// No dependencies.
`timescale 1ns / 1ps

module lsd_mul #(
  parameter int OP_W = 28
) (
  input  logic              clk,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic [2*OP_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ----- rtl/core/load_settle_detector_core.sv -----
// One item is processed at a time: in_ch.ready is low from an accepted item until its
// result is loaded into the output register, which waits while an earlier result is not
// taken. An in-window sample also walks the whole window, one RAM read and one multiplier
// pass per entry, before its result; an out-of-window sample skips the walk. Reset
// (synchronous, active low) restores the register defaults, zeroes the write slot and
// marks every window entry invalid (reads as zero).
`timescale 1ns / 1ps

// Depends on lsd_pkg, lsd_if, lsd_ram and lsd_mul.
module load_settle_detector_core import lsd_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsd_in_if.sink    in_ch,
  lsd_out_if.source out_ch,
  lsd_cfg_if.sink   cfg_ch
);

  // Widths derived from the window length. The signed sum of all entries needs
  // SW bits, the sum of squares QW bits, and DW covers both N*Q and S*S.
  localparam int AW = $clog2(WINDOW_LEN);
  localparam int NW = $clog2(WINDOW_LEN + 1);
  localparam int SW = SAMPLE_W + AW;
  localparam int QW = 2 * SAMPLE_W - 1 + AW;
  localparam int DW = 2 * SW + NW;
  localparam int CW = $clog2(WINDOW_LEN + 2);
  localparam int GW = SAMPLE_W + FRAC_W + 2;

  // Floor reciprocal of N scaled by 2^SW. The quotient estimate it gives is at
  // most one below the true quotient, so one correction step is enough.
  localparam logic [SW-1:0]   RECIP     = SW'((64'd1 << SW) / WINDOW_LEN);
  localparam logic [SW-1:0]   LEN_SW    = SW'(WINDOW_LEN);
  localparam logic [DW-1:0]   LEN_DW    = DW'(WINDOW_LEN);
  localparam logic [2*NW-1:0] LEN_SQ    = (2 * NW)'(WINDOW_LEN * WINDOW_LEN);
  localparam logic [CW-1:0]   CNT_LEN   = CW'(WINDOW_LEN);
  localparam logic [CW-1:0]   CNT_LAST  = CW'(WINDOW_LEN + 1);
  localparam logic [AW-1:0]   SLOT_LAST = AW'(WINDOW_LEN - 1);
  localparam logic [FRAC_W:0] FRAC_ONE  = (FRAC_W + 1)'(1 << FRAC_W);

  // Configuration registers.
  logic                       dir_r;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [SAMPLE_W-1:0] ref_r;
  logic [THR_W-1:0]           thr_r;

  // Sequencer and window bookkeeping.
  lsd_state_t                 state_r, state_nxt;
  logic [AW-1:0]              slot_r;
  logic [WINDOW_LEN-1:0]      vld_r;
  logic [CW-1:0]              cnt_r;
  logic                       rd_vld_r;

  // Working registers of one item.
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       pass_r;
  logic signed [SW-1:0]       sum_r;
  logic [QW-1:0]              sq_r;
  logic [DW-1:0]              lim_r;
  logic [DW-1:0]              ssq_r;
  logic [DW-1:0]              nq_r;
  logic [SW-1:0]              qest_r;
  logic [SW-1:0]              q_r;
  logic                       settled_r;

  // Output register.
  logic                       out_valid_r;
  logic                       out_in_window_r;
  logic                       out_settled_r;
  logic signed [SAMPLE_W-1:0] out_mean_r;

  // Combinational signals.
  logic                       in_acc;
  logic                       out_free;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [SAMPLE_W-1:0]        ram_q;
  logic [SW-1:0]              mul_a;
  logic [SW-1:0]              mul_b;
  logic [2*SW-1:0]            mul_p;
  logic [FRAC_W:0]            gain;
  logic [SAMPLE_W-1:0]        ref_abs;
  logic signed [SAMPLE_W-1:0] samp;
  logic [SAMPLE_W-1:0]        samp_abs;
  logic [SW-1:0]              sum_abs;
  logic [SAMPLE_W+FRAC_W-1:0] rhs_mag;
  logic signed [GW-1:0]       lhs;
  logic signed [GW-1:0]       rhs;
  logic                       pass_now;
  logic [SW-1:0]              rem;
  logic [SW-1:0]              mean_full;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.in_window   = out_in_window_r;
  assign out_ch.settled     = out_settled_r;
  assign out_ch.window_mean = out_mean_r;

  // ---------------------------------------------------------------------------
  // Configuration writes. Unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIRECTION_RST;
      frac_r <= FRACTION_RST;
      ref_r  <= REFERENCE_RST;
      thr_r  <= THRESHOLD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_DIRECTION:          dir_r  <= cfg_ch.data[0];
        CFG_WINDOW_FRACTION:    frac_r <= cfg_ch.data[FRAC_W-1:0];
        CFG_REFERENCE_WEIGHT:   ref_r  <= signed'(cfg_ch.data[SAMPLE_W-1:0]);
        CFG_VARIANCE_THRESHOLD: thr_r  <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sample window. The RAM holds the data; a valid bit per entry makes entries
  // that were never written since reset read as zero.
  // ---------------------------------------------------------------------------
  assign ram_re    = (state_r == ST_ACCUM) && (cnt_r < CNT_LEN);
  assign ram_raddr = cnt_r[AW-1:0];

  lsd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (slot_r),
    .wdata   (in_ch.sample),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        vld_r[slot_r] <= 1'b1;
        slot_r        <= (slot_r == SLOT_LAST) ? '0 : slot_r + AW'(1);
      end
      if (ram_re) begin
        rd_vld_r <= vld_r[ram_raddr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier. Its product is registered and appears
  // in the cycle after the operands are presented.
  // ---------------------------------------------------------------------------
  assign gain      = dir_r ? (FRAC_ONE - {1'b0, frac_r}) : {1'b0, frac_r};
  assign ref_abs   = ref_r[SAMPLE_W-1] ? SAMPLE_W'(-ref_r) : SAMPLE_W'(ref_r);
  assign samp      = rd_vld_r ? signed'(ram_q) : '0;
  assign samp_abs  = samp[SAMPLE_W-1] ? SAMPLE_W'(-samp) : SAMPLE_W'(samp);
  assign sum_abs   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_TEST: begin
        mul_a = SW'(gain);
        mul_b = SW'(ref_abs);
      end
      ST_GATE: begin
        mul_a = SW'(thr_r);
        mul_b = SW'(LEN_SQ);
      end
      ST_ACCUM: begin
        mul_a = SW'(samp_abs);
        mul_b = SW'(samp_abs);
      end
      ST_SQUARE: begin
        mul_a = sum_abs;
        mul_b = sum_abs;
      end
      ST_DIVIDE: begin
        mul_a = sum_abs;
        mul_b = RECIP;
      end
      default: ;
    endcase
  end

  lsd_mul #(
    .OP_W (SW)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_p)
  );

  // ---------------------------------------------------------------------------
  // Window test. In lift direction the sample times 256 must exceed f*R; in
  // lower direction it must fall below (256-f)*R. The product magnitude comes
  // from the multiplier and takes the sign of the reference.
  // ---------------------------------------------------------------------------
  assign rhs_mag  = mul_p[SAMPLE_W+FRAC_W-1:0];
  assign lhs      = {{2{x_r[SAMPLE_W-1]}}, x_r, {FRAC_W{1'b0}}};
  assign rhs      = ref_r[SAMPLE_W-1] ? -signed'({2'b00, rhs_mag}) : signed'({2'b00, rhs_mag});
  assign pass_now = dir_r ? (lhs < rhs) : (lhs > rhs);

  // Quotient correction and sign restore for the mean (truncation toward zero).
  assign rem       = sum_abs - qest_r * LEN_SW;
  assign mean_full = sum_r[SW-1] ? (~q_r + SW'(1)) : q_r;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_TEST;
      ST_TEST:    state_nxt = ST_GATE;
      ST_GATE:    state_nxt = pass_now ? ST_ACCUM : ST_FINISH;
      ST_ACCUM:   if (cnt_r == CNT_LAST) state_nxt = ST_SQUARE;
      ST_SQUARE:  state_nxt = ST_DIVIDE;
      ST_DIVIDE:  state_nxt = ST_FIX;
      ST_FIX:     state_nxt = ST_CORRECT;
      ST_CORRECT: state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Window walk counter. In the accumulate state, count c reads entry c, adds
  // entry c-1 (read data now valid) to the sum and squares it, and adds the
  // square of entry c-2 to the sum of squares. At count zero the product holds
  // threshold * N * N.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == ST_GATE) begin
      cnt_r <= '0;
    end else if (state_r == ST_ACCUM) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r <= in_ch.sample;
        end
      end
      ST_GATE: begin
        pass_r <= pass_now;
        sum_r  <= '0;
        sq_r   <= '0;
      end
      ST_ACCUM: begin
        if (cnt_r == '0) begin
          lim_r <= DW'(mul_p);
        end
        if ((cnt_r != '0) && (cnt_r <= CNT_LEN)) begin
          sum_r <= sum_r + SW'(samp);
        end
        if (cnt_r >= CW'(2)) begin
          sq_r <= sq_r + QW'(mul_p);
        end
      end
      ST_DIVIDE: begin
        ssq_r <= DW'(mul_p);
        nq_r  <= DW'(sq_r) * LEN_DW;
      end
      ST_FIX: begin
        qest_r    <= mul_p[2*SW-1:SW];
        settled_r <= (nq_r - ssq_r) < lim_r;
      end
      ST_CORRECT: begin
        q_r <= qest_r + SW'(rem >= LEN_SW);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register. It is loaded when the sequencer finishes an item and the
  // previous result has been taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      out_in_window_r <= pass_r;
      out_settled_r   <= pass_r && settled_r;
      out_mean_r      <= pass_r ? signed'(mean_full[SAMPLE_W-1:0]) : '0;
    end
  end

endmodule

// ----- rtl/core/lsd_checker.sv -----
// Port-level checks of load_settle_detector_core, bound into that module.
// Depends on load_settle_detector_core_defines.svh and lsd_pkg.
`timescale 1ns / 1ps
`include "load_settle_detector_core_defines.svh"

module lsd_checker import lsd_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_in_window,
  input logic                       out_settled,
  input logic signed [SAMPLE_W-1:0] out_window_mean
);

  // The block works on one item at a time.
  `LSD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A result that is not taken stays unchanged.
  `LSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_window_mean) && $stable(out_in_window) && $stable(out_settled))

  // Settled can only be reported for an in-window sample.
  `LSD_ASSERT_SAME(a_settled_in_window, out_valid && out_settled, out_in_window)

  // An out-of-window result carries a zero mean.
  `LSD_ASSERT_SAME(a_zero_mean_outside, out_valid && !out_in_window, out_window_mean == '0)

endmodule

bind load_settle_detector_core lsd_checker u_lsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_in_window   (out_ch.in_window),
  .out_settled     (out_ch.settled),
  .out_window_mean (out_ch.window_mean)
);
